/* hw/rtl/vn3_pkg.sv */
// shared constants and types for the 3d vector normalizer
`default_nettype none
package vn3_pkg;
    localparam int IN_WIDTH_DEF = 16;
    localparam int OUT_FRAC_DEF = 14;
    localparam int OUT_W        = 16;
    localparam int CFG_W        = 16;

    // control that travels with each word
    typedef struct packed {
        logic valid;
        logic is_zero;
        logic [2:0] neg;
    } t_ctl;
endpackage
`default_nettype wire

/* hw/rtl/vn3_sqrt.sv */
// pipelined integer square root, one result bit per stage
`default_nettype none
module vn3_sqrt #(
    parameter int S_W = 34,
    parameter int R_W = 17,
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [S_W-1:0]   i_sum,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [R_W-1:0]        o_root,
    output logic [TAG_W-1:0]      o_tag
);
    localparam int SP_W = 2 * R_W;

    logic [R_W:0]       r_valid;
    logic [SP_W-1:0]    r_rem  [R_W+1];
    logic [R_W-1:0]     r_root [R_W+1];
    logic [TAG_W-1:0]   r_tag  [R_W+1];

    // stage 0 loads the radicand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= SP_W'(i_sum);
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    // one bit of the root per stage, restoring
    // remainder holds s - root^2, candidate is (root + 2^b)^2 - root^2
    for (genvar k = 0; k < R_W; k++) begin : g_st
        localparam int B = R_W - 1 - k;
        logic [SP_W-1:0] n_trial;
        logic [SP_W-1:0] n_cand;
        always_comb begin
            n_cand  = (SP_W'(r_root[k]) << (B + 1)) + (SP_W'(1) << (2 * B));
            n_trial = r_rem[k] - n_cand;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_en) begin
                r_tag[k+1] <= r_tag[k];
                if (r_rem[k] >= n_cand) begin
                    r_rem[k+1]  <= n_trial;
                    r_root[k+1] <= r_root[k] | (R_W'(1) << B);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
            end
        end
    end

    assign o_valid = r_valid[R_W];
    assign o_root  = r_root[R_W];
    assign o_tag   = r_tag[R_W];
endmodule
`default_nettype wire

/* hw/rtl/vn3_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vn3_div #(
    parameter int N_W = 32,
    parameter int D_W = 17,
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [N_W-1:0]   i_num,
    input  wire logic [D_W-1:0]   i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [N_W-1:0]        o_quo,
    output logic [TAG_W-1:0]      o_tag
);
    logic [N_W:0]     r_valid;
    logic [N_W-1:0]   r_num [N_W+1];
    logic [D_W:0]     r_rem [N_W+1];
    logic [D_W-1:0]   r_den [N_W+1];
    logic [TAG_W-1:0] r_tag [N_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_num[0] <= i_num;
            r_rem[0] <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    // numerator shifts out at top while quotient bits fill from bottom
    for (genvar k = 0; k < N_W; k++) begin : g_st
        logic [D_W:0] n_sh;
        logic [D_W:0] n_sub;
        always_comb begin
            n_sh  = {r_rem[k][D_W-1:0], r_num[k][N_W-1]};
            n_sub = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
                if (n_sh >= {1'b0, r_den[k]}) begin
                    r_rem[k+1] <= n_sub;
                    r_num[k+1] <= {r_num[k][N_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_sh;
                    r_num[k+1] <= {r_num[k][N_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[N_W];
    assign o_quo   = r_num[N_W];
    assign o_tag   = r_tag[N_W];
endmodule
`default_nettype wire

/* hw/rtl/vector_normalize_3d_unit.sv */
// top level of the 3d vector normalizer
//  channel  | dir | signals           | word
//  s_axis   | in  | tvalid/tready    | tdata: in_x, in_y, in_z (low to high)
//  m_axis   | out | tvalid/tready    | tdata: out_x,out_y,out_z; tuser: is_zero
//  cfg      | in  | valid/ready       | min_length
// one word per cycle while the output is not stalled. stages in order: magnitudes,
// squares, root (one bit per stage), dividers (one bit per stage), output register.
// reset clears min_length and all valid bits. a stall on the output freezes
// the whole pipeline; the output register holds its word until taken.
`default_nettype none
module vector_normalize_3d_unit #(
    parameter int IN_WIDTH = vn3_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC = vn3_pkg::OUT_FRAC_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // in_x, in_y, in_z from bit 0 up, zero filled
    input  wire logic [((3*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // out_x, out_y, out_z from bit 0 up
    output logic [47:0]                  m_axis_tdata,
    // is_zero
    output logic [0:0]                   m_axis_tuser,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [vn3_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int OW  = vn3_pkg::OUT_W;
    localparam int SQW = 2 * IN_WIDTH;           // square width
    localparam int SW  = SQW + 2;                // sum width
    localparam int RW  = IN_WIDTH + 1;           // root width
    localparam int NW  = IN_WIDTH + OUT_FRAC + 1; // dividend width
    localparam int TW  = 3 * IN_WIDTH + 3;       // mags + signs
    localparam int DTW = 4;                      // signs + zero flag

    logic [vn3_pkg::CFG_W-1:0] r_min_len;
    logic en;

    // output register drains, whole pipe advances together
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= '0;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    // stage 1: magnitudes
    logic [IN_WIDTH-1:0] r_mag [3];
    logic [2:0] r_neg;
    logic r_v1;
    for (genvar c = 0; c < 3; c++) begin : g_mag
        logic [IN_WIDTH-1:0] n_raw;
        assign n_raw = s_axis_tdata[c*IN_WIDTH +: IN_WIDTH];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_neg[c] <= n_raw[IN_WIDTH-1];
                r_mag[c] <= n_raw[IN_WIDTH-1] ? (~n_raw + 1'b1) : n_raw;
            end
        end
    end

    // stage 2: squares
    logic [SQW-1:0] r_sq [3];
    logic [IN_WIDTH-1:0] r_mag2 [3];
    logic [2:0] r_neg2;
    logic r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
        end
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c]   <= SQW'(r_mag[c]) * SQW'(r_mag[c]);
                r_mag2[c] <= r_mag[c];
            end
            r_neg2 <= r_neg;
        end
    end

    // sum feeds the root pipe
    logic [SW-1:0] n_sum;
    assign n_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);

    logic sq_v;
    logic [RW-1:0] sq_root;
    logic [TW-1:0] sq_tag;
    vn3_sqrt #(.S_W(SW), .R_W(RW), .TAG_W(TW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v2),
        .i_sum(n_sum), .i_tag({r_neg2, r_mag2[2], r_mag2[1], r_mag2[0]}),
        .o_valid(sq_v), .o_root(sq_root), .o_tag(sq_tag)
    );

    // three dividers share the length
    logic [2:0] dv_v;
    logic [NW-1:0] dv_q [3];
    logic [DTW-1:0] dv_tag [3];
    logic n_zero;
    assign n_zero = (sq_root <= RW'(r_min_len));
    for (genvar c = 0; c < 3; c++) begin : g_div
        logic [NW-1:0] n_num;
        logic [RW-1:0] n_den;
        assign n_num = (NW'(sq_tag[c*IN_WIDTH +: IN_WIDTH]) << OUT_FRAC)
                     + NW'(sq_root >> 1);
        assign n_den = n_zero ? RW'(1) : sq_root;
        vn3_div #(.N_W(NW), .D_W(RW), .TAG_W(DTW)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sq_v),
            .i_num(n_num), .i_den(n_den),
            .i_tag({n_zero, sq_tag[TW-1 -: 3]}),
            .o_valid(dv_v[c]), .o_quo(dv_q[c]), .o_tag(dv_tag[c])
        );
    end

    // saturate, sign and register output
    logic [OW-1:0] r_out [3];
    logic r_zero;
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= dv_v[0];
        end
        if (en) begin
            r_zero <= dv_tag[0][3];
            for (int c = 0; c < 3; c++) begin
                logic [NW-1:0] q;
                q = (dv_q[c] > (NW'(1) << OUT_FRAC)) ? (NW'(1) << OUT_FRAC) : dv_q[c];
                if (dv_tag[0][3]) begin
                    r_out[c] <= '0;
                end else if (dv_tag[0][c]) begin
                    r_out[c] <= OW'(~q + 1'b1);
                end else begin
                    r_out[c] <= OW'(q);
                end
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = r_zero;
endmodule
`default_nettype wire
